FILE: design/mbf3_pkg.sv
// shared constants, types and helper functions of the masked 3x3 box filter
package mbf3_pkg;

  // grid limits
  localparam int unsigned MAX_COLS = 512;
  localparam int unsigned MAX_ROWS = 512;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);

  // register and field widths
  localparam int unsigned DIV_W  = 4;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned BW_W   = 3;
  localparam int unsigned CFG_W  = 10;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned LVL_W  = 8;
  localparam int unsigned CELL_W = LVL_W + 1;
  localparam int unsigned WORD_W = 2 * CELL_W;

  // nine levels of at most 254 each
  localparam int unsigned SUM_W    = 12;
  // reciprocal multiply for the divide by 7, 8 or 9
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned RECIP_SH = 15;
  localparam int unsigned QUO_W    = SUM_W + RECIP_W - RECIP_SH;

  localparam logic [LVL_W-1:0] LVL_ROCK = 8'd255;
  localparam logic [LVL_W-1:0] LVL_SAT  = 8'd254;

  localparam logic [DIV_W-1:0] DIV_MIN   = 4'd7;
  localparam logic [DIV_W-1:0] DIV_EIGHT = 4'd8;
  localparam logic [DIV_W-1:0] DIV_MAX   = 4'd9;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 10'd3;
  localparam logic [BW_W-1:0] BW_MIN     = 3'd1;
  localparam logic [BW_W-1:0] BW_MAX     = 3'd4;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_DIVISOR   = 3'd0,
    CFG_GRID_COLS = 3'd1,
    CFG_GRID_ROWS = 3'd2,
    CFG_BORDER    = 3'd3
  } mbf3_cfg_idx_e;

  // one cell: bit 8 blocked, bits 7..0 level
  typedef logic [CELL_W-1:0] mbf3_cell_t;
  // one window column, index 0 oldest row, 2 arriving row
  typedef logic [2:0][CELL_W-1:0] mbf3_col_t;

  // window result handed to the divide stage
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             blocked;
  } mbf3_win_t;

  // level of a cell with rock read as zero
  function automatic logic [LVL_W-1:0] rock_as_zero(input mbf3_cell_t cell_bits);
    logic [LVL_W-1:0] lvl;
    lvl = cell_bits[LVL_W-1:0];
    return (lvl == LVL_ROCK) ? '0 : lvl;
  endfunction

  // scaled reciprocal of a clamped divisor
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] div);
    logic [RECIP_W-1:0] m;
    case (div)
      DIV_MIN:   m = 13'd4682;
      DIV_EIGHT: m = 13'd4096;
      default:   m = 13'd3641;
    endcase
    return m;
  endfunction

endpackage

FILE: design/mbf3_line_ram.sv
// two-row line store, one word per column, with write-to-read forwarding
module mbf3_line_ram (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [mbf3_pkg::COL_W-1:0]        rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [mbf3_pkg::COL_W-1:0]        wr_addr_i,
  input  logic [mbf3_pkg::WORD_W-1:0]       wr_data_i,
  output logic [mbf3_pkg::WORD_W-1:0]       rd_data_o
);

  logic [mbf3_pkg::WORD_W-1:0] mem [mbf3_pkg::MAX_COLS];
  logic [mbf3_pkg::WORD_W-1:0] rd_q;
  logic [mbf3_pkg::WORD_W-1:0] fwd_q;
  logic                        hit_q;

  // memory array, read-before-write on the same edge
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_addr_i];
      fwd_q <= wr_data_i;
    end
  end

  // remember a write that lands on the column being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = hit_q ? fwd_q : rd_q;

endmodule

FILE: design/mbf3_window.sv
// 3x3 neighborhood registers and the nine-cell sum
module mbf3_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  mbf3_pkg::mbf3_col_t   col_i,
  output mbf3_pkg::mbf3_win_t   win_o
);

  // the two most recent columns; the arriving one completes the window
  mbf3_pkg::mbf3_col_t old_q;
  mbf3_pkg::mbf3_col_t mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_q <= '0;
      mid_q <= '0;
    end else if (shift_i) begin
      old_q <= mid_q;
      mid_q <= col_i;
    end
  end

  // sum of the window completed by the arriving column, rock counts as zero
  logic [mbf3_pkg::SUM_W-1:0] sum;
  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = sum + mbf3_pkg::SUM_W'(mbf3_pkg::rock_as_zero(old_q[k]))
                + mbf3_pkg::SUM_W'(mbf3_pkg::rock_as_zero(mid_q[k]))
                + mbf3_pkg::SUM_W'(mbf3_pkg::rock_as_zero(col_i[k]));
    end
  end

  // centre is the middle row of the middle column before the shift
  assign win_o.sum     = sum;
  assign win_o.blocked = mid_q[1][mbf3_pkg::CELL_W-1];

endmodule

FILE: design/masked_box_filter_3x3_stream_top.sv
// top level of the masked 3x3 box filter over a raster cell stream
//
//  channel  direction  handshake             payload
//  input    in         in_valid_i/in_stall_o  old_level_i now_blocked_i frame_start_i
//  output   out        out_valid_o/out_stall_i out_col_o out_row_o new_level_o last_cell_o
//  config   in         cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// One cell per clock is accepted unless the output word is held; the line store read and
// stage one register a cell at its accepting edge, the window sum is registered in stage
// two and the divided level in the output word register.
// The line store is one synchronous memory of both rows, read and written back per cell.
// Reset clears counters, window and pipeline valids and loads default registers; the
// line store is not cleared. A stalled output word holds every stage and the input.
module masked_box_filter_3x3_stream_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mbf3_pkg::LVL_W-1:0]        old_level_i,
  input  logic                              now_blocked_i,
  input  logic                              frame_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mbf3_pkg::COL_W-1:0]        out_col_o,
  output logic [mbf3_pkg::ROW_W-1:0]        out_row_o,
  output logic [mbf3_pkg::LVL_W-1:0]        new_level_o,
  output logic                              last_cell_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbf3_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [mbf3_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned SW = mbf3_pkg::SIZE_W;

  // configuration registers
  logic [mbf3_pkg::DIV_W-1:0] div_q;
  logic [SW-1:0]              cols_q;
  logic [SW-1:0]              rows_q;
  logic [mbf3_pkg::BW_W-1:0]  bw_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= mbf3_pkg::DIV_MAX;
      cols_q <= SW'(mbf3_pkg::MAX_COLS);
      rows_q <= SW'(mbf3_pkg::MAX_ROWS);
      bw_q   <= 3'd2;
    end else if (cfg_valid_i) begin
      case (mbf3_pkg::mbf3_cfg_idx_e'(cfg_index_i))
        mbf3_pkg::CFG_DIVISOR:   div_q  <= cfg_data_i[mbf3_pkg::DIV_W-1:0];
        mbf3_pkg::CFG_GRID_COLS: cols_q <= cfg_data_i[SW-1:0];
        mbf3_pkg::CFG_GRID_ROWS: rows_q <= cfg_data_i[SW-1:0];
        mbf3_pkg::CFG_BORDER:    bw_q   <= cfg_data_i[mbf3_pkg::BW_W-1:0];
        default: ;
      endcase
    end
  end

  // registers clamped to their legal ranges
  logic [mbf3_pkg::DIV_W-1:0] div_c;
  logic [SW-1:0]              cols_c;
  logic [SW-1:0]              rows_c;
  logic [SW-1:0]              bw_c;

  always_comb begin
    if (div_q < mbf3_pkg::DIV_MIN) begin
      div_c = mbf3_pkg::DIV_MIN;
    end else if (div_q > mbf3_pkg::DIV_MAX) begin
      div_c = mbf3_pkg::DIV_MAX;
    end else begin
      div_c = div_q;
    end
    if (cols_q < mbf3_pkg::SIZE_MIN) begin
      cols_c = mbf3_pkg::SIZE_MIN;
    end else if (cols_q > SW'(mbf3_pkg::MAX_COLS)) begin
      cols_c = SW'(mbf3_pkg::MAX_COLS);
    end else begin
      cols_c = cols_q;
    end
    if (rows_q < mbf3_pkg::SIZE_MIN) begin
      rows_c = mbf3_pkg::SIZE_MIN;
    end else if (rows_q > SW'(mbf3_pkg::MAX_ROWS)) begin
      rows_c = SW'(mbf3_pkg::MAX_ROWS);
    end else begin
      rows_c = rows_q;
    end
    if (bw_q < mbf3_pkg::BW_MIN) begin
      bw_c = SW'(mbf3_pkg::BW_MIN);
    end else if (bw_q > mbf3_pkg::BW_MAX) begin
      bw_c = SW'(mbf3_pkg::BW_MAX);
    end else begin
      bw_c = SW'(bw_q);
    end
  end

  // whole pipeline advances unless the output word is held
  logic adv;
  logic accept;
  logic out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // position of the arriving cell
  logic [mbf3_pkg::COL_W-1:0] col_count_q, col_count_d;
  logic [mbf3_pkg::ROW_W-1:0] row_count_q, row_count_d;
  logic [SW-1:0] col_base, row_base, pc, pr, nc, nr;

  always_comb begin
    col_base = frame_start_i ? '0 : SW'(col_count_q);
    row_base = frame_start_i ? '0 : SW'(row_count_q);
    if (col_base >= cols_c) begin
      pc = '0;
      pr = row_base + SW'(1);
    end else begin
      pc = col_base;
      pr = row_base;
    end
    if (pr >= rows_c) begin
      pr = '0;
    end
    nc = pc + SW'(1);
    nr = pr;
    if (nc >= cols_c) begin
      nc = '0;
      nr = pr + SW'(1);
      if (nr >= rows_c) begin
        nr = '0;
      end
    end
    col_count_d = nc[mbf3_pkg::COL_W-1:0];
    row_count_d = nr[mbf3_pkg::ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (accept) begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // stage one: cell waits for its line store word
  logic                       s1_valid_q;
  logic [mbf3_pkg::COL_W-1:0] s1_col_q;
  logic [mbf3_pkg::ROW_W-1:0] s1_row_q;
  mbf3_pkg::mbf3_cell_t       s1_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= pc[mbf3_pkg::COL_W-1:0];
      s1_row_q  <= pr[mbf3_pkg::ROW_W-1:0];
      s1_cell_q <= {now_blocked_i, old_level_i};
    end
  end

  // line store read-modify-write
  logic                        s1_fire;
  logic [mbf3_pkg::WORD_W-1:0] rd_word, wr_word;
  mbf3_pkg::mbf3_col_t         new_col;

  assign s1_fire = s1_valid_q && adv;

  mbf3_line_ram u_line_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pc[mbf3_pkg::COL_W-1:0]),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // row parity picks the bank holding two rows up
  always_comb begin
    if (s1_row_q[0]) begin
      new_col[0] = rd_word[mbf3_pkg::WORD_W-1:mbf3_pkg::CELL_W];
      new_col[1] = rd_word[mbf3_pkg::CELL_W-1:0];
      wr_word    = {s1_cell_q, rd_word[mbf3_pkg::CELL_W-1:0]};
    end else begin
      new_col[0] = rd_word[mbf3_pkg::CELL_W-1:0];
      new_col[1] = rd_word[mbf3_pkg::WORD_W-1:mbf3_pkg::CELL_W];
      wr_word    = {rd_word[mbf3_pkg::WORD_W-1:mbf3_pkg::CELL_W], s1_cell_q};
    end
    new_col[2] = s1_cell_q;
  end

  mbf3_pkg::mbf3_win_t win;

  mbf3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .col_i   (new_col),
    .win_o   (win)
  );

  // interior test and last-cell flag for the centre one up and one left
  logic [SW-1:0] c1, r1;
  logic          emit, last;

  assign c1   = SW'(s1_col_q);
  assign r1   = SW'(s1_row_q);
  assign emit = (c1 >= bw_c + SW'(1)) && (r1 >= bw_c + SW'(1)) &&
                (c1 + bw_c < cols_c + SW'(1)) && (r1 + bw_c < rows_c + SW'(1));
  assign last = (c1 + bw_c == cols_c) && (r1 + bw_c == rows_c);

  // stage two: sum ready for the divide
  logic                       s2_valid_q;
  logic [mbf3_pkg::COL_W-1:0] s2_col_q;
  logic [mbf3_pkg::ROW_W-1:0] s2_row_q;
  mbf3_pkg::mbf3_win_t        s2_win_q;
  logic                       s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_col_q  <= s1_col_q - mbf3_pkg::COL_W'(1);
      s2_row_q  <= s1_row_q - mbf3_pkg::ROW_W'(1);
      s2_win_q  <= win;
      s2_last_q <= last;
    end
  end

  // divide by reciprocal multiply, then saturate; a blocked centre gives the rock code
  logic [mbf3_pkg::SUM_W+mbf3_pkg::RECIP_W-1:0] prod;
  logic [mbf3_pkg::QUO_W-1:0]                   quo;
  logic [mbf3_pkg::LVL_W-1:0]                   level;

  always_comb begin
    prod = (mbf3_pkg::SUM_W + mbf3_pkg::RECIP_W)'(s2_win_q.sum) *
           (mbf3_pkg::SUM_W + mbf3_pkg::RECIP_W)'(mbf3_pkg::recip(div_c));
    quo  = prod[mbf3_pkg::RECIP_SH +: mbf3_pkg::QUO_W];
    if (s2_win_q.blocked) begin
      level = mbf3_pkg::LVL_ROCK;
    end else if (quo > mbf3_pkg::QUO_W'(mbf3_pkg::LVL_SAT)) begin
      level = mbf3_pkg::LVL_SAT;
    end else begin
      level = quo[mbf3_pkg::LVL_W-1:0];
    end
  end

  // output word register
  logic [mbf3_pkg::COL_W-1:0] out_col_q;
  logic [mbf3_pkg::ROW_W-1:0] out_row_q;
  logic [mbf3_pkg::LVL_W-1:0] out_level_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_col_q   <= s2_col_q;
      out_row_q   <= s2_row_q;
      out_level_q <= level;
      out_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign new_level_o = out_level_q;
  assign last_cell_o = out_last_q;

  // a frame start cell lands on column zero of row zero
  a_frame_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i |=> col_count_q == mbf3_pkg::COL_W'(1) && row_count_q == '0)
    else $error("frame start did not restart the position");

  // a non-blocker centre never leaves as rock
  a_no_rock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && adv && !s2_win_q.blocked |=> out_valid_o && new_level_o != mbf3_pkg::LVL_ROCK)
    else $error("filtered level reached the rock code");

  // a cell in the read stage is kept while the output is held
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q))
    else $error("read stage lost its cell under stall");

endmodule

FILE: test/masked_box_filter_3x3_stream_top_tb.sv
// self-checking testbench of the masked 3x3 box filter with a per-cell predictor
module masked_box_filter_3x3_stream_top_tb;

  typedef struct packed {
    logic [mbf3_pkg::LVL_W-1:0] level;
    logic                       blocked;
    logic                       start;
  } grid_cell_t;

  typedef struct packed {
    logic [mbf3_pkg::COL_W-1:0] col;
    logic [mbf3_pkg::ROW_W-1:0] row;
    logic [mbf3_pkg::LVL_W-1:0] level;
    logic                       last;
  } filtered_cell_t;

  // block ports
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [mbf3_pkg::LVL_W-1:0]   old_level_i = '0;
  logic                         now_blocked_i = 1'b0;
  logic                         frame_start_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [mbf3_pkg::COL_W-1:0]   out_col_o;
  logic [mbf3_pkg::ROW_W-1:0]   out_row_o;
  logic [mbf3_pkg::LVL_W-1:0]   new_level_o;
  logic                         last_cell_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [mbf3_pkg::IDX_W-1:0]   cfg_index_i = '0;
  logic [mbf3_pkg::CFG_W-1:0]   cfg_data_i = '0;

  // register copies, reset values
  logic [mbf3_pkg::DIV_W-1:0]   div_reg  = mbf3_pkg::DIV_MAX;
  logic [mbf3_pkg::SIZE_W-1:0]  cols_reg = mbf3_pkg::SIZE_W'(mbf3_pkg::MAX_COLS);
  logic [mbf3_pkg::SIZE_W-1:0]  rows_reg = mbf3_pkg::SIZE_W'(mbf3_pkg::MAX_ROWS);
  logic [mbf3_pkg::BW_W-1:0]    bw_reg   = 3'd2;

  // filter state copy
  bit [mbf3_pkg::CELL_W-1:0]    line_mem [2][mbf3_pkg::MAX_COLS];
  bit [mbf3_pkg::CELL_W-1:0]    win [3][3];
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;

  grid_cell_t                   cells_to_send [$];
  filtered_cell_t               expected_cells [$];
  int unsigned                  cells_pushed = 0;
  int unsigned                  cells_taken = 0;
  int unsigned                  results_seen = 0;
  int unsigned                  fail_count = 0;
  bit                           in_taken = 1'b0;
  int unsigned                  hold_left = 0;
  bit                           hold_done = 1'b0;

  masked_box_filter_3x3_stream_top u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one accepted cell through position counters, line store and window
  task automatic advance_filter(input logic [mbf3_pkg::LVL_W-1:0] level, input logic blocked,
                                input logic start);
    int unsigned ncols, nrows, bord, dv, c, r, sum, quo;
    bit [mbf3_pkg::CELL_W-1:0] word;
    ncols = clamp_u(32'(cols_reg), 32'(mbf3_pkg::SIZE_MIN), mbf3_pkg::MAX_COLS);
    nrows = clamp_u(32'(rows_reg), 32'(mbf3_pkg::SIZE_MIN), mbf3_pkg::MAX_ROWS);
    bord  = clamp_u(32'(bw_reg), 32'(mbf3_pkg::BW_MIN), 32'(mbf3_pkg::BW_MAX));
    dv    = clamp_u(32'(div_reg), 32'(mbf3_pkg::DIV_MIN), 32'(mbf3_pkg::DIV_MAX));
    word  = {blocked, level};
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a position beyond a shrunken grid wraps before use
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= nrows) row_pos = 0;
    c = col_pos;
    r = row_pos;
    // shift window left, new column from both row banks and the arriving cell
    for (int k = 0; k < 2; k++)
      for (int j = 0; j < 3; j++)
        win[k][j] = win[k+1][j];
    win[2][0] = line_mem[r % 2][c];
    win[2][1] = line_mem[(r + 1) % 2][c];
    win[2][2] = word;
    line_mem[r % 2][c] = word;
    // interior centre only
    if (c >= bord + 1 && r >= bord + 1 && c - 1 + bord < ncols && r - 1 + bord < nrows) begin
      if (win[1][1][mbf3_pkg::LVL_W]) begin
        quo = 32'(mbf3_pkg::LVL_ROCK);
      end else begin
        sum = 0;
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++)
            if (win[k][j][mbf3_pkg::LVL_W-1:0] != mbf3_pkg::LVL_ROCK)
              sum += win[k][j][mbf3_pkg::LVL_W-1:0];
        quo = sum / dv;
        if (quo > mbf3_pkg::LVL_SAT) quo = 32'(mbf3_pkg::LVL_SAT);
      end
      expected_cells.push_back('{col: mbf3_pkg::COL_W'(c - 1), row: mbf3_pkg::ROW_W'(r - 1),
                                 level: mbf3_pkg::LVL_W'(quo),
                                 last: (c + bord == ncols) && (r + bord == nrows)});
    end
    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= ncols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= nrows) row_pos = 0;
    end
  endtask

  function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // input word accepted: predict its result
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      advance_filter(old_level_i, now_blocked_i, frame_start_i);
      cells_taken++;
    end
  end

  // sender: hold a stalled word, else offer the next or idle
  always @(negedge clk_i) begin : drive_cells
    grid_cell_t nxt;
    if (!in_valid_i || in_taken) begin
      if (cells_to_send.size() != 0 &&
          ((cells_taken >= 300 && cells_taken < 700) || $urandom_range(0, 99) >= 30)) begin
        nxt = cells_to_send.pop_front();
        in_valid_i    <= 1'b1;
        old_level_i   <= nxt.level;
        now_blocked_i <= nxt.blocked;
        frame_start_i <= nxt.start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off, one stretch without stalls
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100) begin
      out_stall_i <= 1'b1;
      hold_left   <= 250;
      hold_done   <= 1'b1;
    end else if (results_seen >= 200 && results_seen < 350) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
    end
  end

  // output word accepted: compare with the oldest prediction
  always @(posedge clk_i) begin : check_results
    filtered_cell_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      results_seen++;
      if (expected_cells.size() == 0) begin
        $error("unexpected result col %0d row %0d", out_col_o, out_row_o);
        fail_count++;
      end else begin
        want = expected_cells.pop_front();
        check_field("out_col", 9'(want.col), 9'(out_col_o));
        check_field("out_row", 9'(want.row), 9'(out_row_o));
        check_field("new_level", 9'(want.level), 9'(new_level_o));
        check_field("last_cell", 9'(want.last), 9'(last_cell_o));
      end
    end
  end

  task automatic write_reg(input mbf3_pkg::mbf3_cfg_idx_e idx,
                           input logic [mbf3_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mbf3_pkg::CFG_DIVISOR:   div_reg  = data[mbf3_pkg::DIV_W-1:0];
      mbf3_pkg::CFG_GRID_COLS: cols_reg = data[mbf3_pkg::SIZE_W-1:0];
      mbf3_pkg::CFG_GRID_ROWS: rows_reg = data[mbf3_pkg::SIZE_W-1:0];
      mbf3_pkg::CFG_BORDER:    bw_reg   = data[mbf3_pkg::BW_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_cell(input logic [mbf3_pkg::LVL_W-1:0] level, input logic blocked,
                           input logic start);
    cells_to_send.push_back('{level: level, blocked: blocked, start: start});
    cells_pushed++;
  endtask

  // random cells, rock and extremes favored; frame start first unless continuing
  task automatic push_random(input int unsigned n, input bit cont, input int unsigned area);
    logic [mbf3_pkg::LVL_W-1:0] lvl;
    logic st;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    lvl = mbf3_pkg::LVL_ROCK;
        2:       lvl = '0;
        3:       lvl = mbf3_pkg::LVL_SAT;
        default: lvl = mbf3_pkg::LVL_W'($urandom_range(0, 255));
      endcase
      if (i == 0) st = !cont;
      else st = (i % area == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 199) == 0;
      push_cell(lvl, $urandom_range(0, 99) < 15, st);
    end
  endtask

  // wait until nothing is in flight, then let the pipeline empty
  task automatic settle();
    while (cells_to_send.size() != 0 || in_valid_i || expected_cells.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned door_frame [9];
    int unsigned mixed_frame [9];
    bit [8:0] mixed_blk;
    int unsigned old_cols, ncols, nrows, n;
    bit cont;

    door_frame  = '{254, 254, 254, 254, 255, 254, 254, 254, 254};
    mixed_frame = '{0, 255, 0, 7, 0, 8, 255, 1, 0};
    mixed_blk   = 9'b000010001;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // smallest grid: saturation with a rock centre, then a blocker centre after a wrap
    write_reg(mbf3_pkg::CFG_DIVISOR, mbf3_pkg::CFG_W'(mbf3_pkg::DIV_MIN));
    write_reg(mbf3_pkg::CFG_GRID_COLS, mbf3_pkg::SIZE_MIN);
    write_reg(mbf3_pkg::CFG_GRID_ROWS, mbf3_pkg::SIZE_MIN);
    write_reg(mbf3_pkg::CFG_BORDER, mbf3_pkg::CFG_W'(mbf3_pkg::BW_MIN));
    for (int i = 0; i < 9; i++)
      push_cell(mbf3_pkg::LVL_W'(door_frame[i]), 1'b0, i == 0);
    for (int i = 0; i < 9; i++)
      push_cell(mbf3_pkg::LVL_W'(mixed_frame[i]), mixed_blk[i], 1'b0);
    settle();

    // registers below and above range, full sum at divisor nine
    write_reg(mbf3_pkg::CFG_DIVISOR, 10'd15);
    write_reg(mbf3_pkg::CFG_GRID_COLS, 10'd1);
    write_reg(mbf3_pkg::CFG_GRID_ROWS, 10'd2);
    write_reg(mbf3_pkg::CFG_BORDER, 10'd0);
    for (int i = 0; i < 9; i++) push_cell(mbf3_pkg::LVL_SAT, i == 8, i == 0);
    settle();

    // widest grid, one whole frame
    write_reg(mbf3_pkg::CFG_DIVISOR, mbf3_pkg::CFG_W'(mbf3_pkg::DIV_EIGHT));
    write_reg(mbf3_pkg::CFG_GRID_COLS, mbf3_pkg::CFG_W'(mbf3_pkg::MAX_COLS));
    write_reg(mbf3_pkg::CFG_GRID_ROWS, mbf3_pkg::SIZE_MIN);
    write_reg(mbf3_pkg::CFG_BORDER, mbf3_pkg::CFG_W'(mbf3_pkg::BW_MIN));
    push_random(mbf3_pkg::MAX_COLS * 3, 1'b0, mbf3_pkg::MAX_COLS * 3);
    settle();

    // tallest grid, first rows only
    write_reg(mbf3_pkg::CFG_GRID_COLS, mbf3_pkg::SIZE_MIN);
    write_reg(mbf3_pkg::CFG_GRID_ROWS, 10'd1023);
    push_random(60, 1'b0, 3 * mbf3_pkg::MAX_ROWS);
    settle();

    // oversized registers, no interior reached
    write_reg(mbf3_pkg::CFG_DIVISOR, 10'd0);
    write_reg(mbf3_pkg::CFG_GRID_COLS, 10'd1023);
    write_reg(mbf3_pkg::CFG_BORDER, 10'd7);
    push_random(40, 1'b0, mbf3_pkg::MAX_COLS * mbf3_pkg::MAX_ROWS);
    settle();

    // random small grids; some phases carry on mid-frame after a shrink
    while (cells_pushed < 1800) begin
      old_cols = clamp_u(32'(cols_reg), 32'(mbf3_pkg::SIZE_MIN), mbf3_pkg::MAX_COLS);
      if ($urandom_range(0, 3) != 0)
        write_reg(mbf3_pkg::CFG_DIVISOR, mbf3_pkg::CFG_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) != 0)
        write_reg(mbf3_pkg::CFG_GRID_COLS,
                  mbf3_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 10)));
      if ($urandom_range(0, 3) != 0)
        write_reg(mbf3_pkg::CFG_GRID_ROWS,
                  mbf3_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 8)));
      if ($urandom_range(0, 3) != 0)
        write_reg(mbf3_pkg::CFG_BORDER,
                  mbf3_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                               : $urandom_range(1, 2)));
      ncols = clamp_u(32'(cols_reg), 32'(mbf3_pkg::SIZE_MIN), mbf3_pkg::MAX_COLS);
      nrows = clamp_u(32'(rows_reg), 32'(mbf3_pkg::SIZE_MIN), mbf3_pkg::MAX_ROWS);
      cont  = ($urandom_range(0, 3) == 0) && (ncols <= old_cols);
      n     = $urandom_range(1, 2) * ncols * nrows;
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      push_random(n, cont, ncols * nrows);
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: masked_box_filter_3x3_stream_top.f
design/mbf3_pkg.sv
design/mbf3_line_ram.sv
design/mbf3_window.sv
design/masked_box_filter_3x3_stream_top.sv
test/masked_box_filter_3x3_stream_top_tb.sv
